/* rtl/brf_pkg.sv */
`default_nettype none

package brf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_W  = 11;

  // Item kinds; any other code acts as a fill-level query
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Run counter saturates here
  localparam logic [OUT_W-1:0] CNT_MAX = {OUT_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // update pointers, access the store
    logic load;     // move the result into the output register
  } brf_cmd_t;

endpackage

`default_nettype wire

/* rtl/brf_ctrl.sv */
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output brf_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // Output register can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // Commands decoded from state
  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.load    = (state_q == S_LOAD) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/brf_datapath.sv */
`default_nettype none

module brf_datapath
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire brf_cmd_t          cmd_i,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              run_last_i,
  output logic      [BYTE_W-1:0] out_byte_o,
  output logic                   moved_o,
  output logic      [OUT_W-1:0]  run_total_o,
  output logic      [OUT_W-1:0]  fill_level_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = AW + 1;

  // Captured word
  logic [KIND_W-1:0] kind_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;

  // Pointers and run counter
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]    held, held_new;
  logic [OUT_W-1:0] cnt_q, cnt_d;

  // Per-item results
  logic             moved_d, wr_en, rd_en;
  logic [OUT_W-1:0] total_d;
  logic             moved_q, hit_q;
  logic [OUT_W-1:0] total_q, fill_q;

  // Ring store
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_q;

  // Output register
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_moved_q;
  logic [OUT_W-1:0]  out_total_q, out_fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      byte_q <= in_byte_i;
      last_q <= run_last_i;
    end
  end

  // Pointer, counter and result logic for one item
  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    cnt_d   = cnt_q;
    moved_d = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    total_d = '0;
    held    = wp_q - rp_q;

    case (kind_q)
      KIND_PUT: begin
        if (held != PW'(DEPTH)) begin
          wr_en   = 1'b1;
          wp_d    = wp_q + 1'b1;
          moved_d = 1'b1;
        end
      end
      KIND_GET: begin
        if (held != '0) begin
          rd_en   = 1'b1;
          rp_d    = rp_q + 1'b1;
          moved_d = 1'b1;
        end
        // empty after the get: rewind both pointers
        if (wp_d == rp_d) begin
          wp_d = '0;
          rp_d = '0;
        end
      end
      default: ;
    endcase

    // Run counting on put and get only
    if (kind_q == KIND_PUT || kind_q == KIND_GET) begin
      if (moved_d && cnt_q != CNT_MAX) cnt_d = cnt_q + 1'b1;
      if (last_q) begin
        total_d = cnt_d;
        cnt_d   = '0;
      end
    end

    held_new = wp_d - rp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Single-port store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[wp_q[AW-1:0]] <= byte_q;
    if (cmd_i.exec && rd_en) rd_q <= mem[rp_q[AW-1:0]];
  end

  // Pending result, waits for the read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      moved_q <= moved_d;
      hit_q   <= rd_en;
      total_q <= total_d;
      fill_q  <= OUT_W'(held_new);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q  <= hit_q ? rd_q : '0;
      out_moved_q <= moved_q;
      out_total_q <= total_q;
      out_fill_q  <= fill_q;
    end
  end

  assign out_byte_o   = out_byte_q;
  assign moved_o      = out_moved_q;
  assign run_total_o  = out_total_q;
  assign fill_level_o = out_fill_q;

endmodule

`default_nettype wire

/* rtl/byte_ring_fifo_top.sv */
// Byte FIFO on a ring store with one-bit-wider read and write pointers.
// Each accepted word is captured in idle, then its store access (exec) and
// result load (load, held while the output register is full and stalled)
// follow; the input stalls until this controller sequence is done.
// Reset (rst_ni, async, active low) clears pointers, run counter and control;
// the store itself is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_fifo_top
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              run_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [BYTE_W-1:0] out_byte_o,
  output logic                   moved_o,
  output logic      [OUT_W-1:0]  run_total_o,
  output logic      [OUT_W-1:0]  fill_level_o
);

  brf_cmd_t cmd;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .in_byte_i    (in_byte_i),
    .run_last_i   (run_last_i),
    .out_byte_o   (out_byte_o),
    .moved_o      (moved_o),
    .run_total_o  (run_total_o),
    .fill_level_o (fill_level_o)
  );

endmodule

`default_nettype wire

/* rtl/brf_checker.sv */
`default_nettype none

module brf_checker
  import brf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [KIND_W-1:0] kind_i,
  input wire logic [BYTE_W-1:0] in_byte_i,
  input wire logic              run_last_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [BYTE_W-1:0] out_byte_o,
  input wire logic              moved_o,
  input wire logic [OUT_W-1:0]  run_total_o,
  input wire logic [OUT_W-1:0]  fill_level_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // One word in flight: stall right after an accept
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accept");

  // Every accepted word yields an output word in time
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##3 out_valid_o)
    else $error("no output word after accept");

  // No output word without an accepted input word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 3))
    else $error("output word without input word");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(moved_o) && $stable(run_total_o) && $stable(fill_level_o))
    else $error("stalled output word changed");

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (.*);

`default_nettype wire
